// ===== design/baro_temp_pressure_compensation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the barometer compensation block
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

`ifndef SYNTHESIS

// Plain property, checked on every clock edge outside reset
`define BTPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("btpc assertion failed");

// Implication: when ante holds, cons must hold in the same cycle
`define BTPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btpc implication failed");

// Implication: when ante holds, cons must hold in the next cycle
`define BTPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btpc next-cycle check failed");

`else

`define BTPC_ASSERT(lbl, clk, rst_n, prop)
`define BTPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BTPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/btpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation package
// Payload types, coefficient set, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int COEFF_W    = 16;
  localparam int RAW_W      = 24;
  localparam int TEMP_W     = 20;
  localparam int PRES_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_STAGES = 9;

  // Temperature thresholds in 0.01 C
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -20'sd1500;
  localparam logic signed [TEMP_W:0]   VLOW_OFS  = 21'sd1500;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS     = 3'd0,
    REG_OFF      = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] off;
    logic [COEFF_W-1:0] tcs;
    logic [COEFF_W-1:0] tco;
    logic [COEFF_W-1:0] tref;
    logic [COEFF_W-1:0] tempsens;
  } coeff_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic signed [PRES_W-1:0] pressure_fixed;
  } out_item_t;

endpackage

// ===== design/baro_temp_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometer temperature and pressure compensation
// Nine-stage pipeline with second-order low-temperature correction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one raw
//   pressure and raw temperature pair per transaction. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns one result per input:
//   temperature in 0.01 C and pressure in 0.01 mbar with 15 fraction bits.
//   Calibration words are written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while the pipeline is empty; indexes 6 and 7 are ignored.
// Structure: one register per stage from input transaction to result on
//   the output; no multiplier is wider than 25 by 25 bits.
// Throughput: one transaction per cycle while out_stall_i is low.
// Stall: each stage advances when it is empty or the stage after it moves,
//   so bubbles collapse and in_stall_o rises only when all nine stages hold
//   an item and the receiver stalls. Nothing is dropped or repeated.
// Reset: clears all stage valid bits and the calibration words to zero.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_assert.svh"

module baro_temp_pressure_compensation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [btpc_pkg::COEFF_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  btpc_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output btpc_pkg::out_item_t            out_data_o
);

  localparam int N = btpc_pkg::NUM_STAGES;

  btpc_pkg::coeff_t coeff;

  btpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coeff_o    (coeff)
  );

  // --------------------------------------------------------------------------
  // Flow control: per-stage enable, bubbles collapse
  // --------------------------------------------------------------------------
  logic [N-1:0] valid_q, valid_d, en;

  always_comb begin
    en[N-1] = !valid_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < N; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[N-1];

  // --------------------------------------------------------------------------
  // Stage 1: dT = D2 - C5 * 256
  // --------------------------------------------------------------------------
  logic signed [24:0] s1_dt_q, s1_dt_d;
  logic        [23:0] s1_d1_q;

  assign s1_dt_d = $signed({1'b0, in_data_i.raw_temperature})
                 - $signed({1'b0, coeff.tref, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= in_data_i.raw_pressure;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: first-order products and dT squared
  // --------------------------------------------------------------------------
  logic signed [41:0] s2_pt_q, s2_po_q, s2_ps_q;
  logic signed [49:0] s2_pdd_q;
  logic        [23:0] s2_d1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_pt_q  <= $signed({1'b0, coeff.tempsens}) * s1_dt_q;
      s2_po_q  <= $signed({1'b0, coeff.tco}) * s1_dt_q;
      s2_ps_q  <= $signed({1'b0, coeff.tcs}) * s1_dt_q;
      s2_pdd_q <= s1_dt_q * s1_dt_q;
      s2_d1_q  <= s1_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: TEMP, OFF, SENS, T2
  // --------------------------------------------------------------------------
  logic signed [18:0] s3_dlow_d, s3_dlow_q;
  logic signed [19:0] s3_temp_d, s3_temp_q;
  logic signed [39:0] s3_off_d, s3_off_q, s3_sens_d, s3_sens_q;
  logic        [18:0] s3_t2_q;
  logic        [23:0] s3_d1_q;

  assign s3_dlow_d = $signed(s2_pt_q[41:23]);
  assign s3_temp_d = btpc_pkg::TEMP_BASE + $signed({s3_dlow_d[18], s3_dlow_d});
  assign s3_off_d  = $signed({8'h00, coeff.off, 16'h0000})
                   + $signed({{5{s2_po_q[41]}}, s2_po_q[41:7]});
  assign s3_sens_d = $signed({9'h000, coeff.sens, 15'h0000})
                   + $signed({{6{s2_ps_q[41]}}, s2_ps_q[41:8]});

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_dlow_q <= s3_dlow_d;
      s3_temp_q <= s3_temp_d;
      s3_off_q  <= s3_off_d;
      s3_sens_q <= s3_sens_d;
      s3_t2_q   <= s2_pdd_q[49:31];
      s3_d1_q   <= s2_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squares of the distances below 20 C and below -15 C
  // --------------------------------------------------------------------------
  logic signed [20:0] s4_dv;
  logic signed [37:0] s4_sqa_full;
  logic signed [41:0] s4_sqb_full;
  logic        [37:0] s4_sqa_q, s4_sqb_q;
  logic               s4_low_q, s4_vlow_q;
  logic signed [19:0] s4_temp_q;
  logic signed [39:0] s4_off_q, s4_sens_q;
  logic        [18:0] s4_t2_q;
  logic        [23:0] s4_d1_q;

  assign s4_dv       = $signed({s3_temp_q[19], s3_temp_q}) + btpc_pkg::VLOW_OFS;
  assign s4_sqa_full = s3_dlow_q * s3_dlow_q;
  assign s4_sqb_full = s4_dv * s4_dv;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_sqa_q  <= s4_sqa_full[37:0];
      s4_sqb_q  <= s4_sqb_full[37:0];
      s4_low_q  <= s3_dlow_q[18];
      s4_vlow_q <= (s3_temp_q < btpc_pkg::TEMP_VLOW);
      s4_temp_q <= s3_temp_q;
      s4_off_q  <= s3_off_q;
      s4_sens_q <= s3_sens_q;
      s4_t2_q   <= s3_t2_q;
      s4_d1_q   <= s3_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: OFF2, SENS2 and corrected TEMP (squares are non-negative)
  // --------------------------------------------------------------------------
  logic        [41:0] s5_a5, s5_b7, s5_b11, s5_off2_d, s5_sens2_d;
  logic        [41:0] s5_off2_q, s5_sens2_q;
  logic signed [19:0] s5_temp_d, s5_temp_q;
  logic               s5_low_q;
  logic signed [39:0] s5_off_q, s5_sens_q;
  logic        [23:0] s5_d1_q;

  assign s5_a5      = {4'h0, s4_sqa_q} * 42'd5;
  assign s5_b7      = {4'h0, s4_sqb_q} * 42'd7;
  assign s5_b11     = {4'h0, s4_sqb_q} * 42'd11;
  assign s5_off2_d  = (s5_a5 >> 1) + (s4_vlow_q ? s5_b7 : 42'd0);
  assign s5_sens2_d = (s5_a5 >> 2) + (s4_vlow_q ? (s5_b11 >> 1) : 42'd0);
  assign s5_temp_d  = s4_low_q ? (s4_temp_q - $signed({1'b0, s4_t2_q})) : s4_temp_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_off2_q  <= s5_off2_d;
      s5_sens2_q <= s5_sens2_d;
      s5_temp_q  <= s5_temp_d;
      s5_low_q   <= s4_low_q;
      s5_off_q   <= s4_off_q;
      s5_sens_q  <= s4_sens_q;
      s5_d1_q    <= s4_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: apply second-order terms to OFF and SENS
  // --------------------------------------------------------------------------
  logic signed [39:0] s6_off_q, s6_sens_q;
  logic signed [19:0] s6_temp_q;
  logic        [23:0] s6_d1_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_off_q  <= s5_low_q ? (s5_off_q - $signed(s5_off2_q[39:0])) : s5_off_q;
      s6_sens_q <= s5_low_q ? (s5_sens_q - $signed(s5_sens2_q[39:0])) : s5_sens_q;
      s6_temp_q <= s5_temp_q;
      s6_d1_q   <= s5_d1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: D1 * SENS as two partial products
  // --------------------------------------------------------------------------
  logic        [43:0] s7_plo_q;
  logic signed [44:0] s7_phi_q;
  logic signed [39:0] s7_off_q;
  logic signed [19:0] s7_temp_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_plo_q  <= s6_d1_q * s6_sens_q[19:0];
      s7_phi_q  <= $signed({1'b0, s6_d1_q}) * $signed(s6_sens_q[39:20]);
      s7_off_q  <= s6_off_q;
      s7_temp_q <= s6_temp_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: combine partial products (full product fits 64 bits)
  // --------------------------------------------------------------------------
  logic        [63:0] s8_prod_q;
  logic signed [39:0] s8_off_q;
  logic signed [19:0] s8_temp_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_prod_q <= {s7_phi_q[43:0], 20'h00000} + {20'h00000, s7_plo_q};
      s8_off_q  <= s7_off_q;
      s8_temp_q <= s7_temp_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: P = (D1 * SENS) >> 21 - OFF, output register
  // --------------------------------------------------------------------------
  btpc_pkg::out_item_t s9_out_q, s9_out_d;

  always_comb begin
    s9_out_d.temperature    = s8_temp_q;
    s9_out_d.pressure_fixed = $signed({{5{s8_prod_q[63]}}, s8_prod_q[63:21]})
                            - $signed({{8{s8_off_q[39]}}, s8_off_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s9_out_q <= s9_out_d;
    end
  end

  assign out_data_o = s9_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Items in flight change only by accepted transactions
  `BTPC_ASSERT_IMPL(a_item_count, clk_i, rst_ni, $past(rst_ni), ($countones(valid_q) == $countones($past(valid_q)) + int'($past(in_acc)) - int'($past(out_acc))))

  // Input is held off only when every stage is occupied
  `BTPC_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, in_stall_o, (&valid_q))

  // Writes past the last register leave the calibration words untouched
  `BTPC_ASSERT_NEXT(a_cfg_ignore, clk_i, rst_ni, (cfg_we_i && (cfg_idx_i > btpc_pkg::CFG_IDX_W'(btpc_pkg::REG_TEMPSENS))), $stable(coeff))

endmodule

// ===== design/btpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Calibration register file
// Decodes writes to the six calibration words; other indexes are ignored.
// ----------------------------------------------------------------------------
module btpc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [btpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [btpc_pkg::COEFF_W-1:0]       cfg_data_i,
  output btpc_pkg::coeff_t                   coeff_o
);

  btpc_pkg::coeff_t coeff_q, coeff_d;

  // Write decode
  always_comb begin
    coeff_d = coeff_q;
    if (cfg_we_i) begin
      unique case (btpc_pkg::reg_idx_e'(cfg_idx_i))
        btpc_pkg::REG_SENS:     coeff_d.sens     = cfg_data_i;
        btpc_pkg::REG_OFF:      coeff_d.off      = cfg_data_i;
        btpc_pkg::REG_TCS:      coeff_d.tcs      = cfg_data_i;
        btpc_pkg::REG_TCO:      coeff_d.tco      = cfg_data_i;
        btpc_pkg::REG_TREF:     coeff_d.tref     = cfg_data_i;
        btpc_pkg::REG_TEMPSENS: coeff_d.tempsens = cfg_data_i;
        default:                coeff_d          = coeff_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  assign coeff_o = coeff_q;

endmodule
